// ----- hdl/lslf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package lslf_pkg;

  // Operation codes of an input transaction
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_PRED  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOSAMP = 2'd1;
  localparam logic [1:0] ST_SPREAD = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // Width of a fixed-point result field
  localparam int OUT_W = 48;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] x_value;
    logic signed [15:0] y_value;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] prediction;
    logic signed [OUT_W-1:0] slope_out;
    logic signed [OUT_W-1:0] intercept_out;
    logic [1:0]              status;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_PRED,
    CMD_CLEAR,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MSTART,
    B_MWAIT,
    B_DSTART,
    B_DWAIT,
    B_EMIT
  } back_state_t;

endpackage
`default_nettype wire

// ----- hdl/lslf_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lslf_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  input  wire lslf_pkg::in_item_t in_item,
  output logic                   in_full,
  output logic                   cmd_valid,
  output lslf_pkg::cmd_t         cmd,
  input  wire logic              cmd_pop
);
  import lslf_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       cls;
  logic       do_push, do_pop;

  // Classify the incoming transaction
  always_comb begin
    cls.x = in_item.x_value;
    cls.y = in_item.y_value;
    case (in_item.operation)
      OP_ADD:   cls.kind = CMD_ADD;
      OP_PRED:  cls.kind = CMD_PRED;
      OP_CLEAR: cls.kind = CMD_CLEAR;
      default:  cls.kind = CMD_NOP;
    endcase
  end

  assign in_full   = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign do_push   = in_push && !in_full;
  assign do_pop    = cmd_pop && cmd_valid;

  // Advance queue pointers
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold queue entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/lslf_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lslf_mul #(
  parameter int W  = 109,
  parameter int BW = 29
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic signed [W-1:0] a,
  input  wire logic signed [BW-1:0] b,
  output logic                     done,
  output logic signed [W-1:0]      p
);
  localparam int ND  = (BW + 3) / 4;
  localparam int BPW = ND * 4;
  localparam int CNTW = $clog2(ND + 1);

  logic [W-1:0]    amag_r;
  logic [BPW-1:0]  bmag_r;
  logic [W-1:0]    acc_r;
  logic            neg_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r, done_r;
  logic [BW-1:0]   bmag;
  logic [W+3:0]    pp;

  assign bmag = b[BW-1] ? BW'(-b) : BW'(b);
  assign pp   = amag_r * bmag_r[BPW-1 -: 4];

  // Control: count digits, pulse done after the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(ND);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: one radix-16 digit of |b| per cycle, most significant first
  always_ff @(posedge clk) begin
    if (start) begin
      amag_r <= a[W-1] ? W'(-a) : W'(a);
      bmag_r <= {{(BPW-BW){1'b0}}, bmag};
      neg_r  <= a[W-1] ^ b[BW-1];
      acc_r  <= '0;
    end else if (busy_r) begin
      acc_r  <= {acc_r[W-5:0], 4'b0000} + pp[W-1:0];
      bmag_r <= {bmag_r[BPW-5:0], 4'b0000};
    end
  end

  assign done = done_r;
  assign p    = neg_r ? -$signed(acc_r) : $signed(acc_r);

endmodule
`default_nettype wire

// ----- hdl/lslf_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lslf_div #(
  parameter int W  = 109,
  parameter int DW = 56,
  parameter int FB = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [W-1:0]  num,
  input  wire logic [DW-1:0]        den,
  output logic                      done,
  output logic signed [lslf_pkg::OUT_W-1:0] quot
);
  import lslf_pkg::*;

  localparam int CNTW = $clog2(W + 1);
  localparam logic [W-1:0] POS_LIM = W'((64'd1 << (OUT_W - 1)) - 64'd1);
  localparam logic [W-1:0] NEG_LIM = W'(64'd1 << (OUT_W - 1));

  logic [W-1:0]    mag_r, q_r;
  logic [DW-1:0]   rem_r, d_r;
  logic            neg_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r, done_r;
  logic signed [W-1:0] sh;
  logic [DW:0]     trial;
  logic            ge;
  logic            rnd;
  logic [W-1:0]    qr, lim, qs;
  logic [OUT_W-1:0] qm;

  assign sh    = num <<< FB;
  assign trial = {rem_r, mag_r[W-1]};
  assign ge    = (trial >= {1'b0, d_r});

  // Control: one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Restoring division of |num * 2^FB| by den
  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= sh[W-1] ? W'(-sh) : W'(sh);
      neg_r <= sh[W-1];
      d_r   <= den;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? DW'(trial - {1'b0, d_r}) : trial[DW-1:0];
      q_r   <= {q_r[W-2:0], ge};
      mag_r <= {mag_r[W-2:0], 1'b0};
    end
  end

  // Round half away from zero, saturate, restore sign
  always_comb begin
    rnd  = ({rem_r, 1'b0} >= {1'b0, d_r});
    qr   = q_r + {{(W-1){1'b0}}, rnd};
    lim  = neg_r ? NEG_LIM : POS_LIM;
    qs   = (qr > lim) ? lim : qr;
    qm   = qs[OUT_W-1:0];
    quot = neg_r ? -$signed(qm) : $signed(qm);
  end

  assign done = done_r;

endmodule
`default_nettype wire

// ----- hdl/lslf_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lslf_back #(
  parameter int MAX_SAMPLES   = 4096,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cmd_valid,
  input  wire lslf_pkg::cmd_t  cmd,
  output logic                 cmd_pop,
  output logic                 out_empty,
  output lslf_pkg::out_item_t  out_item,
  input  wire logic            out_pop
);
  import lslf_pkg::*;

  localparam int CW   = $clog2(MAX_SAMPLES + 1);
  localparam int SXW  = 16 + CW;
  localparam int SXXW = 30 + CW;
  localparam int SXYW = 31 + CW;
  localparam int DW   = CW + SXXW;
  localparam int W    = SXYW + SXW + 16 + FRACTION_BITS + 4;

  back_state_t state_r, state_nxt;

  logic [CW-1:0]          cnt_r;
  logic signed [SXW-1:0]  sx_r, sy_r;
  logic [SXXW-1:0]        sxx_r;
  logic signed [SXYW-1:0] sxy_r;
  logic [2:0]             k_r;
  logic [1:0]             j_r;
  logic signed [W-1:0]    tmp_r, num_r, icp_r, pred_r;
  logic [DW-1:0]          d_r;
  logic signed [15:0]     qx_r;
  out_item_t              res_r;
  out_item_t              out_r, out_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_load;

  logic                   out_free;
  logic                   full_now;
  logic signed [W-1:0]    sx_w, sy_w, sxx_w, sxy_w, n_w;
  logic signed [W-1:0]    dval;
  logic                   mul_start, mul_done, div_start, div_done;
  logic signed [W-1:0]    mul_a, mul_p, div_n;
  logic signed [SXW-1:0]  mul_b;
  logic signed [OUT_W-1:0] div_q;
  logic signed [31:0]     xx, xy;
  out_item_t              imm;

  assign out_free = !out_valid_r || out_pop;
  assign full_now = (cnt_r >= CW'(MAX_SAMPLES));
  assign sx_w     = {{(W-SXW){sx_r[SXW-1]}}, sx_r};
  assign sy_w     = {{(W-SXW){sy_r[SXW-1]}}, sy_r};
  assign sxx_w    = {{(W-SXXW){1'b0}}, sxx_r};
  assign sxy_w    = {{(W-SXYW){sxy_r[SXYW-1]}}, sxy_r};
  assign n_w      = {{(W-CW){1'b0}}, cnt_r};
  assign dval     = tmp_r - mul_p;
  assign xx       = cmd.x * cmd.x;
  assign xy       = cmd.x * cmd.y;

  // Select multiplier operands per product step
  always_comb begin
    case (k_r)
      3'd0: begin mul_a = sxx_w; mul_b = SXW'(n_w); end
      3'd1: begin mul_a = sx_w;  mul_b = sx_r; end
      3'd2: begin mul_a = sxy_w; mul_b = SXW'(n_w); end
      3'd3: begin mul_a = sy_w;  mul_b = sx_r; end
      3'd4: begin mul_a = sxx_w; mul_b = sy_r; end
      3'd5: begin mul_a = sxy_w; mul_b = sx_r; end
      default: begin mul_a = num_r; mul_b = {{(SXW-16){qx_r[15]}}, qx_r}; end
    endcase
  end

  // Select dividend per quotient step
  always_comb begin
    case (j_r)
      2'd0:    div_n = pred_r;
      2'd1:    div_n = num_r;
      default: div_n = icp_r;
    endcase
  end

  lslf_mul #(.W(W), .BW(SXW)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start),
    .a(mul_a), .b(mul_b), .done(mul_done), .p(mul_p)
  );

  lslf_div #(.W(W), .DW(DW), .FB(FRACTION_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(div_n), .den(d_r), .done(div_done), .quot(div_q)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (cmd_valid) begin
          if (cmd.kind == CMD_PRED) begin
            state_nxt = (cnt_r == '0) ? B_EMIT : B_MSTART;
          end
        end
      end
      B_MSTART: state_nxt = B_MWAIT;
      B_MWAIT: begin
        if (mul_done) begin
          if (k_r == 3'd1 && dval == '0) begin
            state_nxt = B_EMIT;
          end else if (k_r == 3'd6) begin
            state_nxt = B_DSTART;
          end else begin
            state_nxt = B_MSTART;
          end
        end
      end
      B_DSTART: state_nxt = B_DWAIT;
      B_DWAIT: begin
        if (div_done) begin
          state_nxt = (j_r == 2'd2) ? B_EMIT : B_DSTART;
        end
      end
      B_EMIT: begin
        if (out_free) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    mul_start = (state_r == B_MSTART);
    div_start = (state_r == B_DSTART);
    cmd_pop   = 1'b0;
    if (state_r == B_IDLE && cmd_valid) begin
      cmd_pop = (cmd.kind == CMD_PRED) ? 1'b1 : out_free;
    end
  end

  // Immediate result of add, clear and unused codes
  always_comb begin
    imm = '0;
    if (cmd.kind == CMD_ADD && full_now) begin
      imm.status = ST_FULL;
    end
  end

  // Load the result register from an immediate or a finished prediction
  always_comb begin
    out_load = 1'b0;
    out_nxt  = out_r;
    if (state_r == B_IDLE && cmd_pop && cmd.kind != CMD_PRED) begin
      out_load = 1'b1;
      out_nxt  = imm;
    end else if (state_r == B_EMIT && out_free) begin
      out_load = 1'b1;
      out_nxt  = res_r;
    end
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      sx_r        <= '0;
      sy_r        <= '0;
      sxx_r       <= '0;
      sxy_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      // Carry out the command at the head of the queue
      if (state_r == B_IDLE && cmd_pop) begin
        case (cmd.kind)
          CMD_ADD: begin
            if (!full_now) begin
              cnt_r <= cnt_r + 1'b1;
              sx_r  <= sx_r + {{(SXW-16){cmd.x[15]}}, cmd.x};
              sy_r  <= sy_r + {{(SXW-16){cmd.y[15]}}, cmd.y};
              sxx_r <= sxx_r + {{(SXXW-32){1'b0}}, xx};
              sxy_r <= sxy_r + {{(SXYW-32){xy[31]}}, xy};
            end
          end
          CMD_CLEAR: begin
            cnt_r <= '0;
            sx_r  <= '0;
            sy_r  <= '0;
            sxx_r <= '0;
            sxy_r <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // Hold the result register
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // Prediction datapath
  always_ff @(posedge clk) begin
    if (state_r == B_IDLE && cmd_valid && cmd.kind == CMD_PRED) begin
      qx_r  <= cmd.x;
      k_r   <= 3'd0;
      j_r   <= 2'd0;
      res_r <= {{(3*OUT_W){1'b0}}, (cnt_r == '0) ? ST_NOSAMP : ST_OK};
    end
    if (state_r == B_MWAIT && mul_done) begin
      k_r <= k_r + 3'd1;
      case (k_r)
        3'd1: begin
          d_r <= dval[DW-1:0];
          if (dval == '0) begin
            res_r.status <= ST_SPREAD;
          end
        end
        3'd3: num_r  <= dval;
        3'd5: icp_r  <= dval;
        3'd6: pred_r <= mul_p + icp_r;
        default: tmp_r <= mul_p;
      endcase
    end
    if (state_r == B_DWAIT && div_done) begin
      j_r <= j_r + 2'd1;
      case (j_r)
        2'd0:    res_r.prediction    <= div_q;
        2'd1:    res_r.slope_out     <= div_q;
        default: res_r.intercept_out <= div_q;
      endcase
    end
  end

  assign out_empty = !out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

// ----- hdl/least_squares_line_fit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   Ports                          Transaction when
// input     in_push, in_full, in_item      in_push && !in_full
// result    out_pop, out_empty, out_item   out_pop && !out_empty
//
// A predict runs seven products on a radix-16 serial multiplier, then three
// restoring divisions, one bit a cycle over W bits, where
// W = 2*clog2(MAX_SAMPLES+1)+67+FRACTION_BITS (109 at defaults). An empty store
// or a zero x spread cuts this short.
// Reset is synchronous, active low; it empties both queues and zeroes the sums.
// A two-entry command queue keeps taking input while the back end is busy or
// the result register waits to be popped.
module least_squares_line_fit #(
  parameter int MAX_SAMPLES   = 4096,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  input  wire lslf_pkg::in_item_t  in_item,
  output logic                     in_full,
  output logic                     out_empty,
  output lslf_pkg::out_item_t      out_item,
  input  wire logic                out_pop
);
  import lslf_pkg::*;

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  lslf_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_item(in_item),
    .in_full(in_full), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
  );

  lslf_back #(.MAX_SAMPLES(MAX_SAMPLES), .FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
    .out_empty(out_empty), .out_item(out_item), .out_pop(out_pop)
  );

endmodule
`default_nettype wire

// ----- bench/tb_least_squares_line_fit.sv -----
`timescale 1ns / 1ps
module tb_least_squares_line_fit;
  import lslf_pkg::*;

  localparam int FRAC     = 16;
  localparam int CAPACITY = 4096;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t res;
  } drow_t;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  in_item_t  in_item;
  logic      in_full;
  logic      out_empty;
  out_item_t out_item;
  logic      out_pop;

  // Fit state of the line predictor
  int        n_samples;
  longint    acc_x, acc_y, acc_xx, acc_xy;

  out_item_t fit_results_q[$];
  int        n_errors;
  int        n_results;
  int        n_sent;
  drow_t     dir_rows[16];

  least_squares_line_fit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_item  (out_item),
    .out_pop   (out_pop)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("tb_least_squares_line_fit: done, errors");
    $finish;
  end

  // Round v * 2^FRAC / d to nearest, halves away from zero, saturate to 48 bits
  function automatic logic [47:0] scaled_div(logic signed [127:0] v, logic [127:0] d);
    logic signed [127:0] sv;
    logic [127:0] mag, q, rem, lim;
    bit neg;
    sv  = v <<< FRAC;
    neg = sv[127];
    mag = neg ? -sv : sv;
    q   = mag / d;
    rem = mag % d;
    if (rem >= d - rem) q = q + 1;
    lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
    if (q > lim) q = lim;
    if (neg) q = -q;
    return q[47:0];
  endfunction

  function automatic out_item_t status_only(logic [1:0] st);
    out_item_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  // Advance the fit state by one transaction and return its result
  function automatic out_item_t fit_step(in_item_t it);
    out_item_t r;
    logic signed [127:0] n, sx, sy, sxx, sxy, den, num, icp, pred, xq;
    longint xv, yv;
    r  = '0;
    xv = it.x_value;
    yv = it.y_value;
    case (it.operation)
      OP_ADD: begin
        if (n_samples >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          n_samples++;
          acc_x  += xv;
          acc_y  += yv;
          acc_xx += xv * xv;
          acc_xy += xv * yv;
        end
      end
      OP_CLEAR: begin
        n_samples = 0;
        acc_x = 0; acc_y = 0; acc_xx = 0; acc_xy = 0;
      end
      OP_PRED: begin
        if (n_samples == 0) begin
          r.status = ST_NOSAMP;
        end else begin
          n   = n_samples;
          sx  = acc_x;
          sy  = acc_y;
          sxx = acc_xx;
          sxy = acc_xy;
          xq  = xv;
          den = n * sxx - sx * sx;
          if (den[127:64] != 0 || den == 0) begin
            r.status = ST_SPREAD;
          end else begin
            num  = n * sxy - sx * sy;
            icp  = sy * sxx - sx * sxy;
            pred = num * xq + icp;
            r.prediction    = scaled_div(pred, den);
            r.slope_out     = scaled_div(num, den);
            r.intercept_out = scaled_div(icp, den);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offer one transaction, hold it until accepted, then log its expectation
  task automatic push_item(in_item_t it, bit typed, out_item_t res, bit quiet);
    out_item_t e;
    int g;
    g = quiet ? 0 : gap_len();
    if (g > 0) begin
      in_push <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    e = fit_step(it);
    if (typed) e = res;
    fit_results_q = {fit_results_q, e};
    n_sent++;
  endtask

  function automatic in_item_t mk_item(logic [1:0] op, int x, int y);
    in_item_t it;
    it.operation = op;
    it.x_value   = x[15:0];
    it.y_value   = y[15:0];
    return it;
  endfunction

  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (fit_results_q.size() != 0) @(posedge clk);
  endtask

  // Result side: check against the oldest expectation, then pick the next pop
  initial begin : result_side
    int stall_left;
    int long_hold;
    bit hold_done;
    out_item_t e;
    out_pop    = 1'b0;
    stall_left = 0;
    long_hold  = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        n_results++;
        if (fit_results_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_item);
          n_errors++;
        end else begin
          e = fit_results_q.pop_front();
          if (out_item.prediction !== e.prediction) begin
            $display("%0t: prediction exp %h act %h", $time, e.prediction, out_item.prediction);
            n_errors++;
          end
          if (out_item.slope_out !== e.slope_out) begin
            $display("%0t: slope exp %h act %h", $time, e.slope_out, out_item.slope_out);
            n_errors++;
          end
          if (out_item.intercept_out !== e.intercept_out) begin
            $display("%0t: intercept exp %h act %h", $time, e.intercept_out,
                     out_item.intercept_out);
            n_errors++;
          end
          if (out_item.status !== e.status) begin
            $display("%0t: status exp %h act %h", $time, e.status, out_item.status);
            n_errors++;
          end
        end
      end
      if (!hold_done && n_results == 150) begin
        hold_done = 1'b1;
        long_hold = 3000;
      end
      if (long_hold > 0) begin
        long_hold--;
        out_pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else if ((n_results / 100) % 4 != 3 && $urandom_range(0, 99) < 20) begin
        stall_left = gap_len();
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int i, k, n_add, n_pred, base_x, spread, mode;
    bit quiet;
    out_item_t z;
    n_errors  = 0;
    n_results = 0;
    n_sent    = 0;
    n_samples = 0;
    acc_x = 0; acc_y = 0; acc_xx = 0; acc_xy = 0;
    rst_n   = 1'b0;
    in_push = 1'b0;
    in_item = '0;
    z = '0;

    // Directed rows: empty store, unused code, extremes, saturation, spread
    dir_rows[0]  = '{mk_item(OP_PRED, 0, 0), 1, status_only(ST_NOSAMP)};
    dir_rows[1]  = '{mk_item(2'd3, -1, -1), 1, status_only(ST_OK)};
    dir_rows[2]  = '{mk_item(OP_ADD, 32767, -32768), 1, status_only(ST_OK)};
    dir_rows[3]  = '{mk_item(OP_PRED, 5, 0), 1, status_only(ST_SPREAD)};
    dir_rows[4]  = '{mk_item(OP_ADD, 32766, 32767), 1, status_only(ST_OK)};
    dir_rows[5]  = '{mk_item(OP_PRED, -32768, -1), 0, z};
    dir_rows[6]  = '{mk_item(OP_PRED, 32767, 0), 0, z};
    dir_rows[7]  = '{mk_item(OP_CLEAR, 0, 0), 1, status_only(ST_OK)};
    dir_rows[8]  = '{mk_item(OP_PRED, 1, 1), 1, status_only(ST_NOSAMP)};
    dir_rows[9]  = '{mk_item(OP_ADD, -32768, -32768), 1, status_only(ST_OK)};
    dir_rows[10] = '{mk_item(OP_ADD, -32768, 32767), 1, status_only(ST_OK)};
    dir_rows[11] = '{mk_item(OP_PRED, 0, 0), 1, status_only(ST_SPREAD)};
    dir_rows[12] = '{mk_item(OP_ADD, 0, 0), 1, status_only(ST_OK)};
    dir_rows[13] = '{mk_item(OP_ADD, 32767, 32767), 1, status_only(ST_OK)};
    dir_rows[14] = '{mk_item(OP_PRED, -32768, 32767), 0, z};
    dir_rows[15] = '{mk_item(OP_CLEAR, -1, -1), 1, status_only(ST_OK)};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < 16; i++) begin
      push_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res, 1'b0);
    end

    // Random fits: maybe a clear, a burst of samples, a few queries, some noise
    while (n_sent < 1150) begin
      quiet = ((n_sent / 150) % 4 == 2);
      mode  = $urandom_range(0, 9);
      if (mode == 0) begin
        push_item(mk_item(2'($urandom_range(0, 3)), $urandom, $urandom), 0, z, quiet);
      end else begin
        if ($urandom_range(0, 3) != 0) push_item(mk_item(OP_CLEAR, $urandom, $urandom), 0, z, quiet);
        n_add  = $urandom_range(1, 30);
        n_pred = $urandom_range(1, 3);
        base_x = $urandom_range(0, 65535) - 32768;
        spread = (mode == 1) ? 0 : (mode < 5 ? 64 : 65535);
        for (k = 0; k < n_add; k++) begin
          push_item(mk_item(OP_ADD,
                            spread == 65535 ? $urandom : base_x + $urandom_range(0, spread),
                            $urandom), 0, z, quiet);
        end
        for (k = 0; k < n_pred; k++) begin
          push_item(mk_item(OP_PRED, $urandom, $urandom), 0, z, quiet);
        end
      end
      if (n_sent > 600 && n_sent < 640) drain();
    end

    // Fill the store to capacity, then push beyond it
    drain();
    push_item(mk_item(OP_CLEAR, 0, 0), 0, z, 1'b1);
    for (k = 0; k < CAPACITY; k++) begin
      push_item(mk_item(OP_ADD, $urandom, $urandom), 0, z, 1'b1);
    end
    push_item(mk_item(OP_ADD, 1, 1), 1, status_only(ST_FULL), 1'b0);
    push_item(mk_item(OP_ADD, -32768, 32767), 1, status_only(ST_FULL), 1'b0);
    push_item(mk_item(OP_PRED, 32767, 0), 0, z, 1'b0);
    push_item(mk_item(OP_PRED, -32768, 0), 0, z, 1'b0);

    drain();
    repeat (2000) @(posedge clk);
    if (n_errors == 0 && fit_results_q.size() == 0) begin
      $display("tb_least_squares_line_fit: done, clean");
    end else begin
      $display("tb_least_squares_line_fit: done, errors");
    end
    $finish;
  end

endmodule
